@@ src/sorted_priority_queue_defines.svh @@
// Assertion macros shared by the sorted priority queue sources.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted priority queue: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted priority queue: next-cycle check failed");

`endif

@@ src/spq_pkg.sv @@
// Shared constants, status codes and controller/datapath interface types
// for the sorted priority queue. No dependencies.
package spq_pkg;

    localparam int SPQ_DEPTH = 16;
    localparam int KEY_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch a new request
        logic rd_en;      // read the key store into the read register
        logic rd_prev;    // read at index minus one instead of index
        logic wr_en;      // write the key store
        logic wr_prev;    // write at index minus one instead of index
        logic wr_key;     // write the request key instead of the read register
        logic take_head;  // keep the read register as the dequeued key
        logic idx_inc;
        logic idx_dec;
        logic cnt_inc;
        logic cnt_dec;
        logic load_out;   // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_status status;     // outcome decided at capture
        logic    req_deq;    // captured request is a dequeue
        logic    idx_zero;   // index is zero
        logic    idx_ge_cnt; // index has reached the key count
        logic    greater;    // read key is greater than the request key
        logic    out_free;   // result register can take a new item
    } t_dp_stat;

endpackage

@@ src/spq_datapath.sv @@
// Datapath of the sorted priority queue: key store, index and count
// registers, key compare and result register. Depends on spq_pkg.
`include "sorted_priority_queue_defines.svh"

module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  logic                       i_req_type,
    input  logic signed [KEY_W-1:0]    i_key,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic        [STATUS_W-1:0] o_status,
    output logic signed [KEY_W-1:0]    o_key_out,
    output logic        [OCC_W-1:0]    o_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);

    logic [KEY_W-1:0] r_mem [DEPTH];

    logic             r_req;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_rd_data;
    logic [KEY_W-1:0] r_head;
    t_status          r_status;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_count;

    logic [CNT_W-1:0]       idx_m1;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic [KEY_W-1:0]       wr_data;
    logic                   full;
    logic                   empty;
    t_status                n_status;
    logic [OCC_W+CNT_W-1:0] occ_ext;

    // Address and data selection for the single-port key store.
    assign idx_m1  = r_idx - CNT_W'(1);
    assign rd_addr = i_cmd.rd_prev ? idx_m1[AW-1:0] : r_idx[AW-1:0];
    assign wr_addr = i_cmd.wr_prev ? idx_m1[AW-1:0] : r_idx[AW-1:0];
    assign wr_data = i_cmd.wr_key ? r_key : r_rd_data;

    // Outcome of a new request, decided from the count before it.
    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    always_comb begin
        n_status = ST_OK;
        if (!i_req_type && full) begin
            n_status = ST_FULL;
        end else if (i_req_type && empty) begin
            n_status = ST_EMPTY;
        end
    end

    // Key store with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Request registers and the dequeued key.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req    <= i_req_type;
            r_key    <= i_key;
            r_status <= n_status;
            r_head   <= '0;
        end else if (i_cmd.take_head) begin
            r_head <= r_rd_data;
        end
    end

    // Walking index: starts at the count for an insert, at zero for a removal.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx <= i_req_type ? '0 : r_count;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CNT_W'(1);
        end else if (i_cmd.idx_dec) begin
            r_idx <= idx_m1;
        end
    end

    // Number of stored keys.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // Result register; the occupancy wraps at the field width.
    assign occ_ext = {{OCC_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status    <= r_status;
            o_key_out   <= r_head;
            o_occupancy <= occ_ext[OCC_W-1:0];
        end
    end

    // Status toward the controller.
    assign o_stat.status     = r_status;
    assign o_stat.req_deq    = r_req;
    assign o_stat.idx_zero   = (r_idx == '0);
    assign o_stat.idx_ge_cnt = (r_idx >= r_count);
    assign o_stat.greater    = ($signed(r_rd_data) > $signed(r_key));
    assign o_stat.out_free   = !o_valid || i_ready;

    // The count never exceeds the capacity.
    `SPQ_ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    // A new result never overwrites one that has not been taken.
    `SPQ_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, i_cmd.load_out, !o_valid || i_ready)
    // An item that was not served carries a zero key.
    `SPQ_ASSERT_IMPLY(a_zero_on_error, i_clk, i_rst_n, o_valid && (o_status != ST_OK), o_key_out == '0)
    // An insert grows the count by exactly one.
    `SPQ_ASSERT_NEXT(a_count_inc, i_clk, i_rst_n, i_cmd.cnt_inc, r_count == $past(r_count) + CNT_W'(1))

endmodule

@@ src/spq_controller.sv @@
// Controller of the sorted priority queue: sequences insert and removal
// walks over the key store. Depends on spq_pkg.
module spq_controller
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_ENQ_CHK,
        S_ENQ_CMP,
        S_DEQ_CHK,
        S_DEQ_WR,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.status != ST_OK) begin
                    n_state = S_FINISH;
                end else if (i_stat.req_deq) begin
                    n_state = S_DEQ_CHK;
                end else begin
                    n_state = S_ENQ_CHK;
                end
            end
            // Insert: walk down from the top, moving greater keys up one place.
            S_ENQ_CHK: begin
                if (i_stat.idx_zero) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_key  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_ENQ_CMP;
                end
            end
            S_ENQ_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.greater) begin
                    o_cmd.idx_dec = 1'b1;
                    n_state       = S_ENQ_CHK;
                end else begin
                    o_cmd.wr_key  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_FINISH;
                end
            end
            // Removal: take the head, then move every later key down one place.
            S_DEQ_CHK: begin
                if (i_stat.idx_ge_cnt) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_DEQ_WR;
                end
            end
            S_DEQ_WR: begin
                if (i_stat.idx_zero) begin
                    o_cmd.take_head = 1'b1;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_prev = 1'b1;
                end
                o_cmd.idx_inc = 1'b1;
                n_state       = S_DEQ_CHK;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: minimum queue of signed keys kept
// in ascending order. Depends on spq_pkg, spq_controller and spq_datapath.
//
// Usage:
//   Input channel i_valid/o_ready carries one request item: i_req_type 0
//   inserts i_key, 1 removes the smallest key. Output channel o_valid/i_ready
//   carries one result item per request: o_status (0 ok, 1 empty on removal,
//   2 full on insert), o_key_out (removed key, else zero) and o_occupancy
//   (keys stored after the request, modulo 32).
//   Equal keys leave in arrival order.
//   One request is worked at a time: o_ready is high only in the idle state,
//   to which the controller returns as it loads the result, so a new
//   request is not taken before the last one is through.
//   Full or empty outcomes skip the walk. The walk is bound by the
//   single-port key store: each moved key needs a read step and then a
//   compare/write step.
//   The result sits in a register, so a new request is accepted while the
//   previous result waits; if the receiver stalls, the finished request holds
//   until the result register frees and no further request is accepted.
//   Reset empties the queue and drops any pending result; stored keys are
//   not cleared and need no clearing pass.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_req_type,
    input  logic signed [KEY_W-1:0]    i_key,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic        [STATUS_W-1:0] o_status,
    output logic signed [KEY_W-1:0]    o_key_out,
    output logic        [OCC_W-1:0]    o_occupancy
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    spq_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req_type  (i_req_type),
        .i_key       (i_key),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_key_out   (o_key_out),
        .o_occupancy (o_occupancy)
    );

endmodule
